### src/sktab_pkg.sv
`timescale 1ns / 1ps

package sktab_pkg;

  localparam int SLOTS  = 16;
  localparam int KEY_W  = 40;
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SLOT_W = 4;
  localparam int OUTC_W = 3;

  localparam logic [OUTC_W-1:0] OUT_ADDED     = 3'd0;
  localparam logic [OUTC_W-1:0] OUT_PRESENT   = 3'd1;
  localparam logic [OUTC_W-1:0] OUT_FULL      = 3'd2;
  localparam logic [OUTC_W-1:0] OUT_DELETED   = 3'd3;
  localparam logic [OUTC_W-1:0] OUT_NOT_FOUND = 3'd4;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DELETE = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [KEY_W-1:0] card_key;
  } in_beat_t;

  typedef struct packed {
    logic [OUTC_W-1:0] outcome;
    logic [SLOT_W-1:0] slot_index;
  } out_beat_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic             cmp_en;
    logic             upd_en;
    logic             req_del;
    logic [KEY_W-1:0] key;
  } cell_ctl_t;

  // Handed from one cell to the next: priority flags and the first hits seen so far.
  typedef struct packed {
    logic             match_seen;
    logic [IDX_W-1:0] match_idx;
    logic             free_seen;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] cell_idx;
  } cell_link_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_t;

endpackage

### src/sktab_cell.sv
`timescale 1ns / 1ps

module sktab_cell import sktab_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctl_t  ctl,
  input  logic       match_any,
  input  cell_link_t link_in,
  output cell_link_t link_out,
  output logic       busy
);

  logic             busy_r;
  logic             match_r;
  logic [KEY_W-1:0] key_r;
  logic             ins_hit;
  logic             del_hit;

  // Insert lands in the first free cell, and only if no cell anywhere matched.
  assign ins_hit = ctl.upd_en && (ctl.req_del == REQ_INSERT) && !match_any &&
                   !busy_r && !link_in.free_seen;
  assign del_hit = ctl.upd_en && (ctl.req_del == REQ_DELETE) && match_r &&
                   !link_in.match_seen;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      match_r <= 1'b0;
    end else begin
      if (ctl.cmp_en) begin
        match_r <= busy_r && (key_r == ctl.key);
      end
      if (ins_hit) begin
        busy_r <= 1'b1;
      end else if (del_hit) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ins_hit) begin
      key_r <= ctl.key;
    end else if (del_hit) begin
      key_r <= '0;
    end
  end

  always_comb begin
    link_out.match_seen = link_in.match_seen || match_r;
    link_out.match_idx  = link_in.match_seen ? link_in.match_idx : link_in.cell_idx;
    link_out.free_seen  = link_in.free_seen || !busy_r;
    link_out.free_idx   = link_in.free_seen ? link_in.free_idx : link_in.cell_idx;
    link_out.cell_idx   = link_in.cell_idx + IDX_W'(1);
  end

  assign busy = busy_r;

endmodule

### src/serial_key_table_insert_delete_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake           Beat
// in_       input      in_valid/in_stall   in_beat_t  (req_type, card_key)
// out_      output     out_valid/out_stall out_beat_t (outcome, slot_index)
//
// Each request passes through a compare state, in which every cell compares its key and
// registers the result, and an update state, in which the priority chain across the
// cells picks the slot, the chosen cell updates and the result is registered.
// A new request can be taken in the update state, while the current result is registered.
// Synchronous active-low reset empties the table at once.
// A stalled result holds the block in its update cycle until the beat is taken.

module serial_key_table_insert_delete_top import sktab_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  state_t           state_r;
  state_t           state_nxt;
  logic             req_r;
  logic [KEY_W-1:0] key_r;
  logic             out_valid_r;
  out_beat_t        out_r;
  out_beat_t        out_nxt;
  logic             out_free;
  logic             cmp_en;
  logic             upd_go;
  logic             in_acc;
  cell_ctl_t        ctl;
  cell_link_t       links [SLOTS+1];
  logic [SLOTS-1:0] busy_vec;
  cell_link_t       tail;

  assign out_free = !out_valid_r || !out_stall;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    cmp_en    = 1'b0;
    upd_go    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        cmp_en    = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        in_stall = !out_free;
        upd_go   = out_free;
        if (out_free) begin
          state_nxt = in_valid ? ST_CMP : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r <= in_data.req_type;
      key_r <= in_data.card_key;
    end
  end

  always_comb begin
    ctl.cmp_en  = cmp_en;
    ctl.upd_en  = upd_go;
    ctl.req_del = req_r;
    ctl.key     = key_r;
  end

  assign links[0] = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    sktab_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .match_any (tail.match_seen),
      .link_in   (links[i]),
      .link_out  (links[i+1]),
      .busy      (busy_vec[i])
    );
  end

  assign tail = links[SLOTS];

  always_comb begin
    out_nxt.outcome    = OUT_NOT_FOUND;
    out_nxt.slot_index = '0;
    if (req_r == REQ_INSERT) begin
      if (tail.match_seen) begin
        out_nxt.outcome    = OUT_PRESENT;
        out_nxt.slot_index = SLOT_W'(tail.match_idx);
      end else if (tail.free_seen) begin
        out_nxt.outcome    = OUT_ADDED;
        out_nxt.slot_index = SLOT_W'(tail.free_idx);
      end else begin
        out_nxt.outcome = OUT_FULL;
      end
    end else begin
      if (tail.match_seen) begin
        out_nxt.outcome    = OUT_DELETED;
        out_nxt.slot_index = SLOT_W'(tail.match_idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (upd_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_cmp_then_upd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CMP |=> state_r == ST_UPD)
    else $error("compare cycle not followed by update cycle");

  a_added_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_go && out_nxt.outcome == OUT_ADDED) |=>
      $countones(busy_vec) == $countones($past(busy_vec)) + 1)
    else $error("insert reported added but no slot was taken");

  a_deleted_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_go && out_nxt.outcome == OUT_DELETED) |=>
      $countones(busy_vec) + 1 == $countones($past(busy_vec)))
    else $error("delete reported but no slot was freed");

  a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_go && out_nxt.outcome == OUT_FULL) |-> (&busy_vec))
    else $error("table full reported with a free slot");

endmodule
